// ===== hw/rtl/gn3_pkg.sv =====
// gn3_pkg: shared types and constants for the 3d gradient noise block
// no dependencies; imported by the permutation ram and the top level
package gn3_pkg;

  localparam int CELL_BITS = 8;
  localparam int TBL_DEPTH = 1 << CELL_BITS;
  localparam int POS_W     = 24;
  localparam int OUT_W     = 17;
  localparam logic [OUT_W-1:0] OUT_ONE = 17'd65536;

  typedef logic [CELL_BITS-1:0] perm_idx_t;
  typedef logic [7:0]           perm_byte_t;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  // one table write, applied to a ram copy
  typedef struct packed {
    logic       en;
    perm_idx_t  addr;
    perm_byte_t data;
  } perm_wr_t;

endpackage

// ===== hw/rtl/gradient_noise_3d.sv =====
// gradient_noise_3d: pipelined improved 3d gradient noise in fixed point
// depends on gn3_pkg and gn3_perm_ram
//
// usage: a transaction is accepted when start is high and busy is low; busy
// is always low, so one transaction may enter every cycle. in_cmd selects a
// noise evaluation at (in_pos_x, in_pos_y, in_pos_z), unsigned 8.FRAC_BITS,
// or a load of in_entry_value into permutation slot in_entry_index.
// each evaluation gives one result, out_noise_value (1.16, 0..65536) and
// out_clipped, shown for one cycle with out_valid high, from the output
// register at the end of the pipeline. loads give no result.
// throughput is one transaction per
// cycle: the table is held in seven ram copies so the three dependent hash
// lookups each get their own ram stage, and loads walk down the pipeline so
// each copy is written in transaction order. the receiver cannot stall and
// the pipeline never holds. synchronous reset clears all valid bits; table
// contents are undefined until loaded and need no clearing pass.
module gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [gn3_pkg::POS_W-1:0]    in_pos_x,
  input  logic [gn3_pkg::POS_W-1:0]    in_pos_y,
  input  logic [gn3_pkg::POS_W-1:0]    in_pos_z,
  input  logic [gn3_pkg::CELL_BITS-1:0] in_entry_index,
  input  logic [7:0]                   in_entry_value,
  output logic                         out_valid,
  output logic [gn3_pkg::OUT_W-1:0]    out_noise_value,
  output logic                         out_clipped
);
  import gn3_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 4;          // gradients and blended values
  localparam int DW  = F + 5;          // lerp differences
  localparam int TW  = F + 2;          // signed fade operand
  localparam int PW  = DW + TW;        // lerp products
  localparam int CW  = F + 4;          // fade intermediates up to 15 S
  localparam int QW  = F + 2;          // fade polynomial up to about 2 S
  localparam int PRW = 2 * F + 4;      // fade products
  localparam int RW  = F + 6;
  localparam int XW  = RW - 1 + 15;
  localparam int EW  = POS_W + CELL_BITS;

  localparam logic [CW-1:0] S15 = CW'(15) << F;
  localparam logic [CW-1:0] S10 = CW'(10) << F;
  localparam logic signed [W-1:0]  ONE_W = W'(1) << F;
  localparam logic signed [RW-1:0] ONE_R = RW'(1) << F;

  assign busy = 1'b0;

  function automatic logic signed [W-1:0] grad(input logic [3:0] h,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y,
      input logic signed [W-1:0] z);
    logic signed [W-1:0] u;
    logic signed [W-1:0] v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic acc_eval, acc_load;
  assign acc_eval = start && !busy && (in_cmd == CMD_EVAL);
  assign acc_load = start && !busy && (in_cmd == CMD_LOAD);

  logic [EW-1:0] pos_ext [3];
  assign pos_ext[0] = {{CELL_BITS{1'b0}}, in_pos_x};
  assign pos_ext[1] = {{CELL_BITS{1'b0}}, in_pos_y};
  assign pos_ext[2] = {{CELL_BITS{1'b0}}, in_pos_z};

  // ---------------- control pipeline ----------------
  logic ev1_r, ev2_r, ev3_r, ev4_r, ev5_r, ev6_r, ev7_r, ev8_r, ev9_r, ev10_r;
  logic ld1_r, ld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {ev1_r, ev2_r, ev3_r, ev4_r, ev5_r} <= '0;
      {ev6_r, ev7_r, ev8_r, ev9_r, ev10_r} <= '0;
      ld1_r <= 1'b0;
      ld2_r <= 1'b0;
    end else begin
      ev1_r  <= acc_eval;
      ev2_r  <= ev1_r;
      ev3_r  <= ev2_r;
      ev4_r  <= ev3_r;
      ev5_r  <= ev4_r;
      ev6_r  <= ev5_r;
      ev7_r  <= ev6_r;
      ev8_r  <= ev7_r;
      ev9_r  <= ev8_r;
      ev10_r <= ev9_r;
      ld1_r  <= acc_load;
      ld2_r  <= ld1_r;
    end
  end

  // ---------------- hashing through ram copies ----------------
  perm_idx_t  cx, cy1_r, cz1_r, cz2_r;
  perm_idx_t  widx1_r, widx2_r;
  perm_byte_t wval1_r, wval2_r;
  perm_wr_t   wr0, wr1, wr2;

  assign cx  = pos_ext[0][F +: CELL_BITS];
  assign wr0 = '{en: acc_load, addr: in_entry_index, data: in_entry_value};
  assign wr1 = '{en: ld1_r, addr: widx1_r, data: wval1_r};
  assign wr2 = '{en: ld2_r, addr: widx2_r, data: wval2_r};

  always_ff @(posedge clk) begin
    cy1_r   <= pos_ext[1][F +: CELL_BITS];
    cz1_r   <= pos_ext[2][F +: CELL_BITS];
    cz2_r   <= cz1_r;
    widx1_r <= in_entry_index;
    wval1_r <= in_entry_value;
    widx2_r <= widx1_r;
    wval2_r <= wval1_r;
  end

  perm_byte_t p0, p1, pa, pa1, pb, pb1;
  perm_idx_t  a_idx, b_idx, aa, ab, ba, bb;
  perm_byte_t hs [8];

  gn3_perm_ram u_ram0 (.clk(clk), .wr(wr0), .rd_addr0(cx), .rd_addr1(cx + 8'd1),
                       .rd_data0(p0), .rd_data1(p1));

  assign a_idx = p0 + cy1_r;
  assign b_idx = p1 + cy1_r;

  gn3_perm_ram u_ram1 (.clk(clk), .wr(wr1), .rd_addr0(a_idx), .rd_addr1(a_idx + 8'd1),
                       .rd_data0(pa), .rd_data1(pa1));
  gn3_perm_ram u_ram2 (.clk(clk), .wr(wr1), .rd_addr0(b_idx), .rd_addr1(b_idx + 8'd1),
                       .rd_data0(pb), .rd_data1(pb1));

  assign aa = pa  + cz2_r;
  assign ab = pa1 + cz2_r;
  assign ba = pb  + cz2_r;
  assign bb = pb1 + cz2_r;

  // corner index: bit 0 x, bit 1 y, bit 2 z
  gn3_perm_ram u_ram3 (.clk(clk), .wr(wr2), .rd_addr0(aa), .rd_addr1(aa + 8'd1),
                       .rd_data0(hs[0]), .rd_data1(hs[4]));
  gn3_perm_ram u_ram4 (.clk(clk), .wr(wr2), .rd_addr0(ab), .rd_addr1(ab + 8'd1),
                       .rd_data0(hs[2]), .rd_data1(hs[6]));
  gn3_perm_ram u_ram5 (.clk(clk), .wr(wr2), .rd_addr0(ba), .rd_addr1(ba + 8'd1),
                       .rd_data0(hs[1]), .rd_data1(hs[5]));
  gn3_perm_ram u_ram6 (.clk(clk), .wr(wr2), .rd_addr0(bb), .rd_addr1(bb + 8'd1),
                       .rd_data0(hs[3]), .rd_data1(hs[7]));

  // ---------------- fade, one multiply per stage ----------------
  logic [F-1:0]   t1_r [3];
  logic [F-1:0]   t2_r [3];
  logic [F-1:0]   t3_r [3];
  logic [CW-1:0]  m1_r [3];
  logic [QW-1:0]  q2_r [3];
  logic [QW-1:0]  q3_r [3];
  logic [F:0]     fade4_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_fade
    logic [F-1:0]   tin;
    logic [PRW-1:0] prod0, prod1, prod2, prod3;
    logic [CW-1:0]  c;
    assign tin   = pos_ext[g][F-1:0];
    assign prod0 = PRW'(tin) * PRW'(S15 - CW'(tin) * CW'(6));
    assign c     = S10 - m1_r[g];
    assign prod1 = PRW'(t1_r[g]) * PRW'(c);
    assign prod2 = PRW'(t2_r[g]) * PRW'(q2_r[g]);
    assign prod3 = PRW'(t3_r[g]) * PRW'(q3_r[g]);

    always_ff @(posedge clk) begin
      t1_r[g]    <= tin;
      t2_r[g]    <= t1_r[g];
      t3_r[g]    <= t2_r[g];
      m1_r[g]    <= CW'(prod0 >> F);
      q2_r[g]    <= QW'(prod1 >> F);
      q3_r[g]    <= QW'(prod2 >> F);
      fade4_r[g] <= (F + 1)'(prod3 >> F);
    end
  end

  // ---------------- gradients ----------------
  logic signed [W-1:0] off0 [3];
  logic signed [W-1:0] off1 [3];
  logic signed [W-1:0] grad4_r [8];

  for (genvar g = 0; g < 3; g++) begin : g_off
    assign off0[g] = W'(t3_r[g]);
    assign off1[g] = W'(t3_r[g]) - ONE_W;
  end

  for (genvar k = 0; k < 8; k++) begin : g_grad
    always_ff @(posedge clk) begin
      grad4_r[k] <= grad(hs[k][3:0],
                         ((k & 1) != 0) ? off1[0] : off0[0],
                         ((k & 2) != 0) ? off1[1] : off0[1],
                         ((k & 4) != 0) ? off1[2] : off0[2]);
    end
  end

  // ---------------- trilinear blend ----------------
  logic signed [TW-1:0] fu4, fv5, fw5;
  logic [F:0]           fv5_r, fw5_r, fv6_r, fw6_r, fw7_r, fw8_r;
  logic signed [W-1:0]  lo5_r [4];
  logic signed [PW-1:0] prod5_r [4];
  logic signed [W-1:0]  x6_r [4];
  logic signed [W-1:0]  lo7_r [2];
  logic signed [PW-1:0] prod7_r [2];
  logic signed [W-1:0]  y8_r [2];
  logic signed [W-1:0]  lo9_r;
  logic signed [PW-1:0] prod9_r;

  assign fu4 = $signed({1'b0, fade4_r[0]});

  for (genvar k = 0; k < 4; k++) begin : g_lerp_x
    logic signed [DW-1:0] d;
    assign d = DW'(grad4_r[2*k+1]) - DW'(grad4_r[2*k]);
    always_ff @(posedge clk) begin
      lo5_r[k]   <= grad4_r[2*k];
      prod5_r[k] <= fu4 * d;
      x6_r[k]    <= lo5_r[k] + W'(prod5_r[k] >>> F);
    end
  end

  assign fv5 = $signed({1'b0, fv6_r});

  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    logic signed [DW-1:0] d;
    assign d = DW'(x6_r[2*j+1]) - DW'(x6_r[2*j]);
    always_ff @(posedge clk) begin
      lo7_r[j]   <= x6_r[2*j];
      prod7_r[j] <= fv5 * d;
      y8_r[j]    <= lo7_r[j] + W'(prod7_r[j] >>> F);
    end
  end

  assign fw5 = $signed({1'b0, fw8_r});

  logic signed [DW-1:0] dz;
  assign dz = DW'(y8_r[1]) - DW'(y8_r[0]);

  always_ff @(posedge clk) begin
    fv5_r   <= fade4_r[1];
    fw5_r   <= fade4_r[2];
    fv6_r   <= fv5_r;
    fw6_r   <= fw5_r;
    fw7_r   <= fw6_r;
    fw8_r   <= fw7_r;
    lo9_r   <= y8_r[0];
    prod9_r <= fw5 * dz;
  end

  // ---------------- output scaling and saturation ----------------
  logic signed [W-1:0]  n9;
  logic signed [RW-1:0] r9;
  logic [XW-1:0]        wide9;
  logic [OUT_W-1:0]     val_nxt;
  logic                 clip_nxt;
  logic [OUT_W-1:0]     val_r;
  logic                 clip_r;

  assign n9    = lo9_r + W'(prod9_r >>> F);
  assign r9    = {{(RW - W){n9[W-1]}}, n9} + ONE_R;
  assign wide9 = {r9[RW-2:0], 15'd0} >> F;

  always_comb begin
    if (r9[RW-1]) begin
      val_nxt  = '0;
      clip_nxt = 1'b1;
    end else if (wide9 > XW'(OUT_ONE)) begin
      val_nxt  = OUT_ONE;
      clip_nxt = 1'b1;
    end else begin
      val_nxt  = wide9[OUT_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    clip_r <= clip_nxt;
  end

  assign out_valid       = ev10_r;
  assign out_noise_value = val_r;
  assign out_clipped     = clip_r;

endmodule

// ===== hw/rtl/gn3_perm_ram.sv =====
// gn3_perm_ram: one copy of the 256 x 8 permutation table, one write and two
// registered reads per cycle; depends on gn3_pkg
module gn3_perm_ram (
  input  logic                clk,
  input  gn3_pkg::perm_wr_t   wr,
  input  gn3_pkg::perm_idx_t  rd_addr0,
  input  gn3_pkg::perm_idx_t  rd_addr1,
  output gn3_pkg::perm_byte_t rd_data0,
  output gn3_pkg::perm_byte_t rd_data1
);
  import gn3_pkg::*;

  perm_byte_t mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// ===== hw/rtl/gn3_checker.sv =====
// gn3_checker: port level checks for gradient_noise_3d, bound to the top level
// depends on gn3_pkg
module gn3_checker #(
  parameter int LATENCY = 10
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_cmd,
  input logic                      out_valid,
  input logic [gn3_pkg::OUT_W-1:0] out_noise_value,
  input logic                      out_clipped
);
  import gn3_pkg::*;

  // an evaluation transaction gives its result after the fixed latency
  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_EVAL) |-> ##LATENCY out_valid)
    else $error("evaluation gave no result at the expected cycle");

  // a load transaction never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |-> ##LATENCY !out_valid)
    else $error("load produced a result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_noise_value <= OUT_ONE))
    else $error("noise value above one");

  // saturation only lands on the bounds
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_noise_value == '0 || out_noise_value == OUT_ONE))
    else $error("clipped result not at a bound");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
  .out_valid(out_valid), .out_noise_value(out_noise_value), .out_clipped(out_clipped)
);

// ===== bench/gn3_noise_checker.sv =====
// gn3_noise_checker: watches the command and result channels of gradient_noise_3d,
// predicts each noise result from its own permutation table copy and compares
// depends on gn3_pkg
module gn3_noise_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_cmd,
  input  logic [gn3_pkg::POS_W-1:0]     in_pos_x,
  input  logic [gn3_pkg::POS_W-1:0]     in_pos_y,
  input  logic [gn3_pkg::POS_W-1:0]     in_pos_z,
  input  logic [gn3_pkg::CELL_BITS-1:0] in_entry_index,
  input  logic [7:0]                    in_entry_value,
  input  logic                          out_valid,
  input  logic [gn3_pkg::OUT_W-1:0]     out_noise_value,
  input  logic                          out_clipped,
  output int                            errors,
  output int                            pending
);
  import gn3_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clip;
  } noise_res_t;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  perm_byte_t perm [TBL_DEPTH];
  noise_res_t noise_q[$];

  function automatic longint fade(longint t);
    longint c, p;
    c = 10 * ONE - ((t * (15 * ONE - 6 * t)) >> FRAC_BITS);
    p = (t * c) >> FRAC_BITS;
    p = (t * p) >> FRAC_BITS;
    return (t * p) >> FRAC_BITS;
  endfunction

  // arithmetic shift gives the floor for negative differences
  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FRAC_BITS);
  endfunction

  function automatic longint slope(perm_byte_t hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic perm_byte_t hp(int i);
    return perm[i & (TBL_DEPTH - 1)];
  endfunction

  function automatic noise_res_t predict_noise(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                               logic [POS_W-1:0] pz);
    int cx, cy, cz, a, aa, ab, b, ba, bb;
    longint fx, fy, fz, fu, fv, fw, x1, x2, x3, x4, y1, y2, r, v;
    noise_res_t res;
    cx = (px >> FRAC_BITS) & (TBL_DEPTH - 1);
    cy = (py >> FRAC_BITS) & (TBL_DEPTH - 1);
    cz = (pz >> FRAC_BITS) & (TBL_DEPTH - 1);
    fx = px & (ONE - 1);
    fy = py & (ONE - 1);
    fz = pz & (ONE - 1);
    fu = fade(fx);
    fv = fade(fy);
    fw = fade(fz);
    a  = (hp(cx) + cy) & (TBL_DEPTH - 1);
    aa = (hp(a) + cz) & (TBL_DEPTH - 1);
    ab = (hp(a + 1) + cz) & (TBL_DEPTH - 1);
    b  = (hp(cx + 1) + cy) & (TBL_DEPTH - 1);
    ba = (hp(b) + cz) & (TBL_DEPTH - 1);
    bb = (hp(b + 1) + cz) & (TBL_DEPTH - 1);
    x1 = blend(slope(hp(aa), fx, fy, fz), slope(hp(ba), fx - ONE, fy, fz), fu);
    x2 = blend(slope(hp(ab), fx, fy - ONE, fz), slope(hp(bb), fx - ONE, fy - ONE, fz), fu);
    y1 = blend(x1, x2, fv);
    x3 = blend(slope(hp(aa + 1), fx, fy, fz - ONE),
               slope(hp(ba + 1), fx - ONE, fy, fz - ONE), fu);
    x4 = blend(slope(hp(ab + 1), fx, fy - ONE, fz - ONE),
               slope(hp(bb + 1), fx - ONE, fy - ONE, fz - ONE), fu);
    y2 = blend(x3, x4, fv);
    r = blend(y1, y2, fw) + ONE;
    res.clip = 1'b0;
    if (r < 0) begin
      res.value = '0;
      res.clip  = 1'b1;
    end else begin
      v = (r << 15) >> FRAC_BITS;
      if (v > longint'(OUT_ONE)) begin
        v = OUT_ONE;
        res.clip = 1'b1;
      end
      res.value = v[OUT_W-1:0];
    end
    return res;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    noise_res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (noise_q.size() == 0) begin
          $error("noise result with nothing expected: value %0d", out_noise_value);
          errors++;
        end else begin
          want = noise_q.pop_front();
          if (out_noise_value !== want.value) begin
            $error("noise_value expected %0d actual %0d", want.value, out_noise_value);
            errors++;
          end
          if (out_clipped !== want.clip) begin
            $error("clipped expected %0d actual %0d", want.clip, out_clipped);
            errors++;
          end
        end
      end
      // table updates apply in transaction order, same as the pipeline
      if (start && !busy) begin
        if (cmd_t'(in_cmd) == CMD_LOAD) perm[in_entry_index] = in_entry_value;
        else noise_q.push_back(predict_noise(in_pos_x, in_pos_y, in_pos_z));
      end
      pending = noise_q.size();
    end
  end
endmodule

// ===== bench/tb.sv =====
// tb: stimulus and verdict for gradient_noise_3d
// depends on gn3_pkg, gradient_noise_3d and gn3_noise_checker
module tb;
  import gn3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk, rst_n, start, busy;
  cmd_t                 in_cmd;
  logic [POS_W-1:0]     in_pos_x, in_pos_y, in_pos_z;
  logic [CELL_BITS-1:0] in_entry_index;
  logic [7:0]           in_entry_value;
  logic                 out_valid, out_clipped;
  logic [OUT_W-1:0]     out_noise_value;
  int                   errors, pending, cycles;
  int                   idle_pct;

  gradient_noise_3d dut (.*);
  gn3_noise_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [POS_W-1:0] z, logic [7:0] idx, logic [7:0] val);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= c;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pos_z       <= z;
    in_entry_index <= idx;
    in_entry_value <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic eval_at(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    send(CMD_EVAL, x, y, z, 8'($urandom), 8'($urandom));
  endtask

  task automatic load_entry(logic [7:0] idx, logic [7:0] val);
    send(CMD_LOAD, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), idx, val);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0:       return {8'($urandom), 16'($urandom_range(15))};
      1:       return {8'($urandom), 16'(16'hFFFF - $urandom_range(15))};
      default: return POS_W'($urandom);
    endcase
  endfunction

  initial begin
    int pct [4] = '{0, 52, 0, 20};
    start = 1'b0; in_cmd = CMD_EVAL; in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_entry_index = '0; in_entry_value = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every slot before any evaluation; include both extreme bytes
    for (int i = 0; i < TBL_DEPTH; i++)
      load_entry(8'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));

    eval_at('0, '0, '0);
    eval_at('1, '1, '1);
    eval_at(24'h00FFFF, 24'h000000, 24'h00FFFF);
    eval_at(24'hFF0000, 24'hFFFFFF, 24'h008000);
    eval_at(24'h018000, 24'h7F8000, 24'hFF8000);
    eval_at(24'hFF0001, 24'h00FFFE, 24'h800000);
    eval_at(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
    eval_at(24'h004000, 24'h00C000, 24'h002000);
    load_entry(8'hFF, 8'h00);
    load_entry(8'h00, 8'hFF);
    eval_at(24'hFF7FFF, 24'h00FFFF, 24'hFFFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pct[ph % 4];
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(9) < 2) load_entry(8'($urandom), 8'($urandom));
        else eval_at(rand_pos(), rand_pos(), rand_pos());
      end
      // hold off until the pipeline has drained
      @(negedge clk);
      start <= 1'b0;
      while (pending != 0) @(posedge clk);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
